/* rtl/prt_pkg.sv */
package prt_pkg;

	// Field widths of the transaction payloads.
	localparam int CMD_W    = 2;
	localparam int TAG_W    = 20;
	localparam int PARTNO_W = 32;
	localparam int TOT_W    = 17;
	localparam int KIND_W   = 2;
	localparam int IDX_W    = 6;
	localparam int CNT_W    = 7;
	localparam int OFF_W    = 16;

	// Width of the shared adder: one bit above the message size for the sign.
	localparam int ALU_W = TOT_W + 1;

	// Command codes of an input transaction.
	localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DATA  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	// Reply codes of a result transaction.
	localparam logic [KIND_W-1:0] KIND_INIT_OK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ALL_RX   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RESEND   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_INIT_REPLY,
		S_DATA,
		S_ALL,
		S_SCAN
	} state_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [TAG_W-1:0]    session_tag;
		logic [PARTNO_W-1:0] part_number;
		logic [TOT_W-1:0]    total_bytes;
	} item_t;

	typedef struct packed {
		logic [KIND_W-1:0] reply_kind;
		logic [IDX_W-1:0]  part_index;
		logic [CNT_W-1:0]  missing_count;
		logic [OFF_W-1:0]  write_offset;
		logic              complete;
		logic              last;
	} result_t;

	typedef struct packed {
		alu_op_t          op;
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] result;
		logic             neg;
		logic             zero;
	} alu_rsp_t;

endpackage

/* rtl/prt_alu.sv */
module prt_alu (
	input  prt_pkg::alu_req_t req,
	output prt_pkg::alu_rsp_t rsp
);

	logic [prt_pkg::ALU_W-1:0] sum;

	// One adder serves both the size subtraction and the scan increment.
	always_comb begin
		unique case (req.op)
			prt_pkg::ALU_ADD: sum = req.a + req.b;
			prt_pkg::ALU_SUB: sum = req.a - req.b;
			default:          sum = req.a + req.b;
		endcase
	end

	// Operands stay below the top bit, so that bit is the sign of a difference.
	always_comb begin
		rsp.result = sum;
		rsp.neg    = sum[prt_pkg::ALU_W-1];
		rsp.zero   = (sum == '0);
	end

endmodule

/* rtl/prt_ctrl.sv */
module prt_ctrl #(
	parameter int MAX_PARTS  = 64,
	parameter int PART_BYTES = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  prt_pkg::item_t              item,
	input  logic [prt_pkg::TAG_W-1:0]   own_session_id,
	output logic                        res_valid,
	input  logic                        res_ready,
	output prt_pkg::result_t            res,
	output prt_pkg::alu_req_t           alu_req,
	input  prt_pkg::alu_rsp_t           alu_rsp
);

	localparam int IW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;

	prt_pkg::state_t state_q, state_d;

	logic                          initialized_q;
	logic                          all_done_q;
	logic [prt_pkg::CNT_W-1:0]     part_total_q;
	logic [prt_pkg::CNT_W-1:0]     missing_q;
	logic [MAX_PARTS-1:0]          map_q;
	logic [prt_pkg::TOT_W-1:0]     rem_q;
	logic [prt_pkg::CNT_W-1:0]     cnt_q;
	logic [prt_pkg::IDX_W-1:0]     idx_q;
	logic [prt_pkg::CNT_W-1:0]     remain_q;
	logic [prt_pkg::IDX_W-1:0]     p_q;
	logic [prt_pkg::OFF_W-1:0]     off_q;

	logic                          accept;
	logic                          res_take;
	logic                          tag_ok;
	logic                          part_in_range;
	logic                          part_new;
	logic [prt_pkg::IDX_W-1:0]     in_p;
	logic [prt_pkg::OFF_W-1:0]     in_off;
	logic                          div_done;
	logic                          cur_bit;

	// Decode of the incoming transaction while idle.
	assign accept        = in_valid && in_ready;
	assign res_take      = res_valid && res_ready;
	assign tag_ok        = (item.session_tag == own_session_id);
	assign in_p          = item.part_number[prt_pkg::IDX_W-1:0];
	assign part_in_range = (item.part_number[prt_pkg::PARTNO_W-1:prt_pkg::CNT_W] == '0)
		&& (item.part_number[prt_pkg::CNT_W-1:0] < part_total_q);
	assign part_new      = part_in_range && !map_q[in_p[IW-1:0]];
	assign in_off        = prt_pkg::OFF_W'(in_p) * prt_pkg::OFF_W'(PART_BYTES);

	// The division stops when the size is used up or the count saturates.
	assign div_done = (rem_q == '0) || (cnt_q == prt_pkg::CNT_W'(MAX_PARTS));
	assign cur_bit  = map_q[idx_q[IW-1:0]];

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			prt_pkg::S_IDLE: begin
				if (accept) begin
					unique case (item.command)
						prt_pkg::CMD_INIT: begin
							if (tag_ok) begin
								state_d = initialized_q ? prt_pkg::S_INIT_REPLY : prt_pkg::S_DIV;
							end
						end
						prt_pkg::CMD_DATA: begin
							if (part_new) begin
								state_d = prt_pkg::S_DATA;
							end
						end
						prt_pkg::CMD_QUERY: begin
							if (tag_ok) begin
								state_d = (missing_q == '0) ? prt_pkg::S_ALL : prt_pkg::S_SCAN;
							end
						end
						default: state_d = prt_pkg::S_IDLE;
					endcase
				end
			end
			prt_pkg::S_DIV: begin
				if (div_done) begin
					state_d = prt_pkg::S_INIT_REPLY;
				end
			end
			prt_pkg::S_INIT_REPLY, prt_pkg::S_DATA, prt_pkg::S_ALL: begin
				if (res_take) begin
					state_d = prt_pkg::S_IDLE;
				end
			end
			prt_pkg::S_SCAN: begin
				if (res_take && res.last) begin
					state_d = prt_pkg::S_IDLE;
				end
			end
			default: state_d = prt_pkg::S_IDLE;
		endcase
	end

	// Output logic: handshake, result fields and the request to the shared adder.
	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		res       = '0;
		alu_req.op = prt_pkg::ALU_ADD;
		alu_req.a  = prt_pkg::ALU_W'(idx_q);
		alu_req.b  = prt_pkg::ALU_W'(1);
		unique case (state_q)
			prt_pkg::S_IDLE: begin
				in_ready = 1'b1;
			end
			prt_pkg::S_DIV: begin
				alu_req.op = prt_pkg::ALU_SUB;
				alu_req.a  = prt_pkg::ALU_W'(rem_q);
				alu_req.b  = prt_pkg::ALU_W'(PART_BYTES);
			end
			prt_pkg::S_INIT_REPLY: begin
				res_valid      = 1'b1;
				res.reply_kind = prt_pkg::KIND_INIT_OK;
				res.complete   = all_done_q;
				res.last       = 1'b1;
			end
			prt_pkg::S_DATA: begin
				res_valid         = 1'b1;
				res.reply_kind    = prt_pkg::KIND_ACCEPTED;
				res.part_index    = p_q;
				res.missing_count = missing_q;
				res.write_offset  = off_q;
				res.complete      = all_done_q;
				res.last          = 1'b1;
			end
			prt_pkg::S_ALL: begin
				res_valid      = 1'b1;
				res.reply_kind = prt_pkg::KIND_ALL_RX;
				res.complete   = all_done_q;
				res.last       = 1'b1;
			end
			prt_pkg::S_SCAN: begin
				res_valid         = !cur_bit;
				res.reply_kind    = prt_pkg::KIND_RESEND;
				res.part_index    = idx_q;
				res.missing_count = missing_q;
				res.complete      = all_done_q;
				res.last          = (remain_q == prt_pkg::CNT_W'(1));
			end
			default: in_ready = 1'b0;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Session state, received map and the working registers of the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initialized_q <= 1'b0;
			all_done_q    <= 1'b0;
			part_total_q  <= '0;
			missing_q     <= '0;
			map_q         <= '0;
			rem_q         <= '0;
			cnt_q         <= '0;
			idx_q         <= '0;
			remain_q      <= '0;
			p_q           <= '0;
			off_q         <= '0;
		end else begin
			unique case (state_q)
				prt_pkg::S_IDLE: begin
					if (accept) begin
						unique case (item.command)
							prt_pkg::CMD_INIT: begin
								if (tag_ok && !initialized_q) begin
									rem_q <= item.total_bytes;
									cnt_q <= '0;
								end
							end
							prt_pkg::CMD_DATA: begin
								if (part_new) begin
									map_q[in_p[IW-1:0]] <= 1'b1;
									missing_q <= missing_q - prt_pkg::CNT_W'(1);
									if (missing_q == prt_pkg::CNT_W'(1)) begin
										all_done_q <= 1'b1;
									end
									p_q   <= in_p;
									off_q <= in_off;
								end
							end
							prt_pkg::CMD_QUERY: begin
								if (tag_ok) begin
									if (missing_q == '0) begin
										all_done_q <= 1'b1;
									end else begin
										idx_q    <= '0;
										remain_q <= missing_q;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				prt_pkg::S_DIV: begin
					if (div_done) begin
						part_total_q  <= cnt_q;
						missing_q     <= cnt_q;
						map_q         <= '0;
						initialized_q <= 1'b1;
					end else begin
						// A remainder at or below one part closes the last partial part.
						rem_q <= (alu_rsp.neg || alu_rsp.zero) ? '0
							: alu_rsp.result[prt_pkg::TOT_W-1:0];
						cnt_q <= cnt_q + prt_pkg::CNT_W'(1);
					end
				end
				prt_pkg::S_SCAN: begin
					if (cur_bit) begin
						idx_q <= alu_rsp.result[prt_pkg::IDX_W-1:0];
					end else if (res_take) begin
						idx_q    <= alu_rsp.result[prt_pkg::IDX_W-1:0];
						remain_q <= remain_q - prt_pkg::CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_scan_remain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == prt_pkg::S_SCAN |-> remain_q != '0 && remain_q <= missing_q)
		else $error("resend scan runs with no missing part left");

	a_missing_bound: assert property (@(posedge clk) disable iff (!arst_n)
		missing_q <= part_total_q)
		else $error("missing count exceeds part count");

	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == prt_pkg::S_SCAN && res_take && res.last |=> state_q == prt_pkg::S_IDLE)
		else $error("resend scan did not end after its last entry");

	a_div_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == prt_pkg::S_DIV |-> !initialized_q && cnt_q <= prt_pkg::CNT_W'(MAX_PARTS))
		else $error("part count division out of order");
`endif

endmodule

/* rtl/part_reassembly_tracker.sv */
// Receiver-side part tracker for a selective-repeat message transfer.
// Input channel (in_valid/in_ready) takes one command per transaction: an
// init request, a data part or a query for the received state. Results
// leave on out_valid/out_ready, one transaction per reply or resend entry,
// with last set on the final one of a command. The user writes
// own_session_id through cfg_we/cfg_wdata only while the block is idle;
// the block itself does not enforce this. A data part or a repeated init
// moves to a reply state whose result is taken into the output register
// before the next acceptance. A first init runs the shared adder once per
// part to form the part count, min(ceil(total_bytes / PART_BYTES),
// MAX_PARTS). A query with missing parts walks the received map one index
// per cycle with the same adder while the receiver keeps up. Commands that
// give no result (tag mismatch, duplicate or out-of-range part, unused
// code) leave the block idle. in_ready is low while a command is busy.
// Reset clears the received map, the session state and own_session_id.
// When the receiver stalls, the output register holds its result and the
// sequencer waits with the next one.
module part_reassembly_tracker #(
	parameter int MAX_PARTS  = 64,
	parameter int PART_BYTES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [prt_pkg::TAG_W-1:0]     cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [prt_pkg::CMD_W-1:0]     command,
	input  logic [prt_pkg::TAG_W-1:0]     session_tag,
	input  logic [prt_pkg::PARTNO_W-1:0]  part_number,
	input  logic [prt_pkg::TOT_W-1:0]     total_bytes,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [prt_pkg::KIND_W-1:0]    reply_kind,
	output logic [prt_pkg::IDX_W-1:0]     part_index,
	output logic [prt_pkg::CNT_W-1:0]     missing_count,
	output logic [prt_pkg::OFF_W-1:0]     write_offset,
	output logic                          complete,
	output logic                          last
);

	logic [prt_pkg::TAG_W-1:0] own_session_id_q;
	prt_pkg::item_t            item;
	prt_pkg::result_t          res;
	prt_pkg::result_t          out_res_q;
	logic                      res_valid;
	logic                      res_ready;
	logic                      out_valid_q;
	prt_pkg::alu_req_t         alu_req;
	prt_pkg::alu_rsp_t         alu_rsp;

	// Session tag register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_session_id_q <= '0;
		end else if (cfg_we) begin
			own_session_id_q <= cfg_wdata;
		end
	end

	assign item.command     = command;
	assign item.session_tag = session_tag;
	assign item.part_number = part_number;
	assign item.total_bytes = total_bytes;

	prt_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	prt_ctrl #(
		.MAX_PARTS  (MAX_PARTS),
		.PART_BYTES (PART_BYTES)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.item           (item),
		.own_session_id (own_session_id_q),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.res            (res),
		.alu_req        (alu_req),
		.alu_rsp        (alu_rsp)
	);

	// Output register: takes a new result when empty or being drained.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign reply_kind    = out_res_q.reply_kind;
	assign part_index    = out_res_q.part_index;
	assign missing_count = out_res_q.missing_count;
	assign write_offset  = out_res_q.write_offset;
	assign complete      = out_res_q.complete;
	assign last          = out_res_q.last;

endmodule

/* test/prt_checker.sv */
`timescale 1ns / 1ps

module prt_checker
	import prt_pkg::*;
#(
	parameter int MAX_PARTS  = 64,
	parameter int PART_BYTES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [TAG_W-1:0]    cfg_wdata,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [CMD_W-1:0]    command,
	input  logic [TAG_W-1:0]    session_tag,
	input  logic [PARTNO_W-1:0] part_number,
	input  logic [TOT_W-1:0]    total_bytes,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [KIND_W-1:0]   reply_kind,
	input  logic [IDX_W-1:0]    part_index,
	input  logic [CNT_W-1:0]    missing_count,
	input  logic [OFF_W-1:0]    write_offset,
	input  logic                complete,
	input  logic                last,
	output int                  mismatches,
	output int                  pending,
	output int                  commands_seen,
	output int                  commands_answered,
	output int                  replies_seen,
	output int                  resends_seen
);

	// Shadow copy of the tracker: session tag, arming, part count and received map.
	logic [TAG_W-1:0]     own_tag;
	logic                 armed;
	logic                 all_rx;
	logic [CNT_W-1:0]     part_count;
	logic [MAX_PARTS-1:0] rx_map;

	// Replies still owed by the block, oldest first.
	result_t expected_q[$];

	int n_bad;
	int n_cmds;
	int n_answered;
	int n_replies;
	int n_resends;

	// Number of parts of the current message not yet received.
	function automatic int missing_parts();
		int n;
		n = 0;
		for (int i = 0; i < part_count; i++) begin
			if (!rx_map[i])
				n++;
		end
		return n;
	endfunction

	// Queues one reply; the completion flag reflects the state after the command.
	function automatic void owe_reply(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx,
		int miss, int off, logic fin);
		result_t r;
		r.reply_kind    = kind;
		r.part_index    = idx;
		r.missing_count = CNT_W'(miss);
		r.write_offset  = OFF_W'(off);
		r.complete      = all_rx;
		r.last          = fin;
		expected_q.push_back(r);
	endfunction

	// Applies one accepted command transaction to the shadow state and queues its replies.
	function automatic void predict_replies(logic [CMD_W-1:0] cmd, logic [TAG_W-1:0] tag,
		logic [PARTNO_W-1:0] part, logic [TOT_W-1:0] total);
		int cnt;
		int miss;
		int k;
		int owed_before;
		logic [IDX_W-1:0] idx;
		owed_before = expected_q.size();
		case (cmd)
			CMD_INIT: if (tag == own_tag) begin
				// Only the first matching init sizes the message; later ones just get the reply.
				if (!armed) begin
					cnt = (int'(total) + PART_BYTES - 1) / PART_BYTES;
					if (cnt > MAX_PARTS)
						cnt = MAX_PARTS;
					part_count = CNT_W'(cnt);
					rx_map     = '0;
					armed      = 1'b1;
				end
				owe_reply(KIND_INIT_OK, '0, 0, 0, 1'b1);
			end
			CMD_DATA: if (part < part_count) begin
				// Data parts carry no tag check; duplicates are dropped silently.
				idx = part[IDX_W-1:0];
				if (!rx_map[idx]) begin
					rx_map[idx] = 1'b1;
					miss = missing_parts();
					if (miss == 0)
						all_rx = 1'b1;
					owe_reply(KIND_ACCEPTED, idx, miss, int'(idx) * PART_BYTES, 1'b1);
				end
			end
			CMD_QUERY: if (tag == own_tag) begin
				miss = missing_parts();
				if (miss == 0) begin
					all_rx = 1'b1;
					owe_reply(KIND_ALL_RX, '0, 0, 0, 1'b1);
				end else begin
					// One resend entry per missing part, ascending, last one flagged.
					k = 0;
					for (int i = 0; i < part_count; i++) begin
						if (!rx_map[i]) begin
							k++;
							owe_reply(KIND_RESEND, IDX_W'(i), miss, 0, k == miss);
						end
					end
				end
			end
			default: ;
		endcase
		n_cmds++;
		if (expected_q.size() > owed_before)
			n_answered++;
	endfunction

	// Compares one accepted result transaction with the oldest owed reply.
	function automatic void check_reply();
		result_t seen;
		result_t want;
		seen.reply_kind    = reply_kind;
		seen.part_index    = part_index;
		seen.missing_count = missing_count;
		seen.write_offset  = write_offset;
		seen.complete      = complete;
		seen.last          = last;
		n_replies++;
		if (seen.reply_kind == KIND_RESEND)
			n_resends++;
		if (expected_q.size() == 0) begin
			if (n_bad < 10)
				$display("%0t: result with nothing owed: kind %0d index %0d missing %0d",
					$time, seen.reply_kind, seen.part_index, seen.missing_count);
			n_bad++;
		end else begin
			want = expected_q.pop_front();
			if (seen.reply_kind != want.reply_kind || seen.part_index != want.part_index ||
				seen.missing_count != want.missing_count ||
				seen.write_offset != want.write_offset ||
				seen.complete != want.complete || seen.last != want.last) begin
				if (n_bad < 10) begin
					$display("%0t: expected kind %0d index %0d missing %0d offset %0d done %0b last %0b",
						$time, want.reply_kind, want.part_index, want.missing_count,
						want.write_offset, want.complete, want.last);
					$display("%0t:      got kind %0d index %0d missing %0d offset %0d done %0b last %0b",
						$time, seen.reply_kind, seen.part_index, seen.missing_count,
						seen.write_offset, seen.complete, seen.last);
				end
				n_bad++;
			end
		end
	endfunction

	// Watches the configuration port and both channels at every clock edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_tag    = '0;
			armed      = 1'b0;
			all_rx     = 1'b0;
			part_count = '0;
			rx_map     = '0;
			expected_q.delete();
			n_bad      = 0;
			n_cmds     = 0;
			n_answered = 0;
			n_replies  = 0;
			n_resends  = 0;
		end else begin
			if (cfg_we)
				own_tag = cfg_wdata;
			if (in_valid && in_ready)
				predict_replies(command, session_tag, part_number, total_bytes);
			if (out_valid && out_ready)
				check_reply();
		end
		mismatches        <= n_bad;
		pending           <= expected_q.size();
		commands_seen     <= n_cmds;
		commands_answered <= n_answered;
		replies_seen      <= n_replies;
		resends_seen      <= n_resends;
	end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
	import prt_pkg::*;

	localparam int MAX_PARTS      = 64;
	localparam int PART_BYTES     = 1024;
	localparam int HALF_PERIOD    = 10;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int PHASE_ANSWERS  = 44;
	localparam int RANDOM_PHASES  = 6;

	localparam logic [CMD_W-1:0] CMD_UNUSED     = 2'd3;
	localparam logic [TAG_W-1:0] TAG_ALL_ONES   = '1;
	localparam logic [TAG_W-1:0] TAG_TOP        = 20'd1000000;
	localparam logic [TOT_W-1:0] TOTAL_ALL_ONES = '1;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SLOW,
		RX_PULSE
	} rx_mode_t;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                cfg_we      = 1'b0;
	logic [TAG_W-1:0]    cfg_wdata   = '0;
	logic                in_valid    = 1'b0;
	logic                in_ready;
	logic [CMD_W-1:0]    command     = '0;
	logic [TAG_W-1:0]    session_tag = '0;
	logic [PARTNO_W-1:0] part_number = '0;
	logic [TOT_W-1:0]    total_bytes = '0;
	logic                out_valid;
	logic                out_ready   = 1'b0;
	logic [KIND_W-1:0]   reply_kind;
	logic [IDX_W-1:0]    part_index;
	logic [CNT_W-1:0]    missing_count;
	logic [OFF_W-1:0]    write_offset;
	logic                complete;
	logic                last;

	int mismatches;
	int pending;
	int commands_seen;
	int commands_answered;
	int replies_seen;
	int resends_seen;

	int               idle_cycles    = 0;
	int               burst_left     = 1;
	int               rx_left        = 0;
	int               settings_used  = 1;
	rx_mode_t         rx_mode        = RX_OPEN;
	logic [TAG_W-1:0] cur_tag        = '0;

	always #(HALF_PERIOD) clk = ~clk;

	part_reassembly_tracker #(
		.MAX_PARTS (MAX_PARTS),
		.PART_BYTES(PART_BYTES)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.session_tag  (session_tag),
		.part_number  (part_number),
		.total_bytes  (total_bytes),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.reply_kind   (reply_kind),
		.part_index   (part_index),
		.missing_count(missing_count),
		.write_offset (write_offset),
		.complete     (complete),
		.last         (last)
	);

	prt_checker #(
		.MAX_PARTS (MAX_PARTS),
		.PART_BYTES(PART_BYTES)
	) u_tracker_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.command          (command),
		.session_tag      (session_tag),
		.part_number      (part_number),
		.total_bytes      (total_bytes),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.reply_kind       (reply_kind),
		.part_index       (part_index),
		.missing_count    (missing_count),
		.write_offset     (write_offset),
		.complete         (complete),
		.last             (last),
		.mismatches       (mismatches),
		.pending          (pending),
		.commands_seen    (commands_seen),
		.commands_answered(commands_answered),
		.replies_seen     (replies_seen),
		.resends_seen     (resends_seen)
	);

	// The receiver switches between open, random, slow and periodic stall patterns.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(16, 160);
		end else begin
			rx_left = rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN: out_ready <= 1'b1;
			RX_COIN: out_ready <= 1'($urandom_range(0, 1));
			RX_SLOW: out_ready <= ($urandom_range(0, 7) == 0);
			default: out_ready <= rx_left[2];
		endcase
	end

	// The run is stopped if no transaction moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Presents one command transaction and holds it until accepted, then maybe pauses.
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [TAG_W-1:0] tag,
		input logic [PARTNO_W-1:0] part, input logic [TOT_W-1:0] total);
		in_valid    <= 1'b1;
		command     <= cmd;
		session_tag <= tag;
		part_number <= part;
		total_bytes <= total;
		do @(posedge clk); while (!in_ready);
		burst_left = burst_left - 1;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 48)
				: $urandom_range(1, 8);
		end
	endtask

	// Holds the sender until every owed reply has come and the block has settled.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the session tag register; only called while the block is idle.
	task automatic write_session(input logic [TAG_W-1:0] tag);
		cfg_we    <= 1'b1;
		cfg_wdata <= tag;
		@(posedge clk);
		cfg_we  <= 1'b0;
		cur_tag = tag;
		settings_used++;
	endtask

	// Mostly well-formed traffic for the current session, with some noise mixed in.
	task automatic random_item();
		int                  pick;
		logic [CMD_W-1:0]    cmd;
		logic [TAG_W-1:0]    tag;
		logic [PARTNO_W-1:0] part;
		logic [TOT_W-1:0]    total;
		pick  = $urandom_range(0, 99);
		tag   = cur_tag;
		part  = $urandom();
		total = TOT_W'($urandom());
		if (pick < 40) begin
			cmd = CMD_QUERY;
		end else if (pick < 65) begin
			cmd = CMD_DATA;
			tag = TAG_W'($urandom());
			if (pick < 58)
				part = $urandom_range(0, MAX_PARTS - 1);
			else if (pick < 62)
				part = $urandom_range(MAX_PARTS, MAX_PARTS + 8);
		end else if (pick < 85) begin
			cmd = CMD_INIT;
		end else if (pick < 93) begin
			cmd = pick[0] ? CMD_INIT : CMD_QUERY;
			tag = cur_tag ^ TAG_W'($urandom_range(1, 20'hFFFFF));
		end else begin
			cmd = CMD_UNUSED;
			tag = TAG_W'($urandom());
		end
		send_item(cmd, tag, part, total);
	endtask

	initial begin
		int phase_goal;
		int base;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Before any init, with the session tag still at its reset value.
		send_item(CMD_UNUSED, TAG_ALL_ONES, '1, TOTAL_ALL_ONES);
		send_item(CMD_DATA, '0, '0, '0);
		send_item(CMD_INIT, 20'd1, '0, TOTAL_ALL_ONES);
		send_item(CMD_QUERY, TAG_ALL_ONES, '0, '0);
		send_item(CMD_QUERY, '0, '1, '0);
		drain();
		write_session(TAG_TOP);

		// Oversized init arms the full map, then repeated inits and edge part numbers.
		send_item(CMD_INIT, TAG_TOP, '0, TOTAL_ALL_ONES);
		send_item(CMD_INIT, TAG_TOP, '0, '0);
		send_item(CMD_INIT, TAG_TOP, '1, 17'd65536);
		send_item(CMD_DATA, '0, '0, '0);
		send_item(CMD_DATA, TAG_ALL_ONES, MAX_PARTS - 1, '0);
		send_item(CMD_DATA, '0, MAX_PARTS - 1, '0);
		send_item(CMD_DATA, '0, MAX_PARTS, '0);
		send_item(CMD_DATA, '0, '1, '0);
		send_item(CMD_DATA, '0, 32'hFFFF_FFC0, '0);
		send_item(CMD_QUERY, TAG_TOP, '0, '0);
		send_item(CMD_QUERY, TAG_ALL_ONES, '0, '0);
		send_item(CMD_INIT, '0, '0, 17'd1);
		send_item(CMD_UNUSED, '0, '0, '0);
		send_item(CMD_DATA, '0, 32'd1, '0);

		// Random phases, each under its own session tag.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain();
			case (ph)
				0: write_session(TAG_ALL_ONES);
				1: write_session('0);
				2: write_session(TAG_TOP);
				default: write_session(TAG_W'($urandom_range(0, 1000000)));
			endcase
			phase_goal = commands_answered + PHASE_ANSWERS;
			while (commands_answered < phase_goal)
				random_item();
		end

		// Every part once in rotated order completes the message; a query confirms it.
		drain();
		base = $urandom_range(0, MAX_PARTS - 1);
		for (int k = 0; k < MAX_PARTS; k++)
			send_item(CMD_DATA, TAG_W'($urandom()), PARTNO_W'((base + k) % MAX_PARTS),
				TOT_W'($urandom()));
		send_item(CMD_QUERY, cur_tag, $urandom(), TOT_W'($urandom()));
		drain();
		repeat (16) @(posedge clk);

		$display("Run covered %0d commands, %0d of them answered, under %0d session tags.",
			commands_seen, commands_answered, settings_used);
		$display("Checked %0d result transactions, %0d of them resend entries.",
			replies_seen, resends_seen);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
